// ----- hw/rtl/iota_pkg.sv -----
// shared types and constants for the interval overlap type accumulator
package iota_pkg;

   localparam int ANNO_DEPTH  = 4096;
   localparam int PILE_DEPTH  = 4096;
   localparam int CLASS_COUNT = 8;
   localparam int ANNO_AW     = $clog2(ANNO_DEPTH);
   localparam int PILE_AW     = $clog2(PILE_DEPTH);
   localparam int CLASS_W     = 3;
   localparam logic [12:0] COUNT_MAX = 13'd8191;

   typedef enum logic [1:0] {
      OP_LOAD_ANNO = 2'd0,
      OP_LOAD_PILE = 2'd1,
      OP_QUERY     = 2'd2,
      OP_CLEAR     = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  chrom_id;
      logic [30:0] item_start;
      logic [30:0] item_end;
      logic [2:0]  region_class;
      logic [23:0] pileup_level;
   } req_type;

   typedef struct packed {
      logic [2:0]  class_index;
      logic [63:0] class_area;
      logic [31:0] class_width;
      logic [12:0] class_count;
      logic        last_result;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic               latch_query;
      logic               clear_acc;
      logic               anno_rd;
      logic [ANNO_AW-1:0] anno_addr;
      logic               anno_eval;
      logic               pile_rd;
      logic [PILE_AW-1:0] pile_addr;
      logic               pile_eval;
      logic               prod_add;
      logic               emit;
      logic [CLASS_W-1:0] emit_class;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic anno_hit;
   } dp_status_type;

endpackage

// ----- hw/rtl/iota_datapath.sv -----
// table memories, overlap arithmetic and per-type accumulators
module iota_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  iota_pkg::req_type      req_data,
   input  logic                   anno_we,
   input  logic [iota_pkg::ANNO_AW-1:0] anno_wa,
   input  logic                   pile_we,
   input  logic [iota_pkg::PILE_AW-1:0] pile_wa,
   input  iota_pkg::dp_cmd_type   cmd,
   output iota_pkg::dp_status_type status,
   output iota_pkg::rsp_type      rsp_data
);
   import iota_pkg::*;

   // annotation memory: start(31) end+1(32) chrom(8) class(3)
   logic [73:0] anno_mem [ANNO_DEPTH];
   logic [73:0] anno_rd_ff;
   logic [93:0] pile_rd_ff;
   logic [93:0] pile_mem_hi [PILE_DEPTH];

   logic [7:0]  q_chrom_ff;
   logic [30:0] q_start_ff, q_end_ff;

   // current intersection
   logic [32:0] is_ff, ie_ff;
   logic [CLASS_W-1:0] cls_ff;

   logic [63:0] area_ff  [CLASS_COUNT];
   logic [31:0] width_ff [CLASS_COUNT];
   logic [12:0] count_ff [CLASS_COUNT];

   logic [31:0] len_ff;
   logic [23:0] lvl_ff;
   logic        len_ok_ff;
   logic [55:0] prod_ff;
   logic        prod_ok_ff;

   always_ff @(posedge clock) begin
      if (anno_we)
         anno_mem[anno_wa] <= {req_data.item_start, {1'b0, req_data.item_end} + 32'd1,
                               req_data.chrom_id, req_data.region_class};
      if (cmd.anno_rd)
         anno_rd_ff <= anno_mem[cmd.anno_addr];
   end

   always_ff @(posedge clock) begin
      if (pile_we)
         pile_mem_hi[pile_wa] <= {req_data.item_start, req_data.item_end,
                                  req_data.chrom_id, req_data.pileup_level};
      if (cmd.pile_rd)
         pile_rd_ff <= pile_mem_hi[cmd.pile_addr];
   end

   // annotation fields
   logic [30:0] a_s;
   logic [31:0] a_e;
   logic [7:0]  a_c;
   logic [2:0]  a_k;
   assign {a_s, a_e, a_c, a_k} = anno_rd_ff;

   // overlap-or-touch test in 35-bit signed terms
   logic signed [34:0] qs, qe, as_x, ae_x, hi_a, lo_a;
   logic               a_meet;
   always_comb begin
      qs   = 35'(q_start_ff);
      qe   = 35'(q_end_ff);
      as_x = 35'(a_s);
      ae_x = 35'(a_e);
      hi_a = (qe > ae_x) ? qe : ae_x;
      lo_a = (qs < as_x) ? qs : as_x;
      a_meet = (hi_a - lo_a) <= ((qe - qs) + (ae_x - as_x));
   end

   logic [32:0] is_n, ie_n;
   assign is_n = (a_s > q_start_ff) ? 33'(a_s) : 33'(q_start_ff);
   assign ie_n = (33'(a_e) < 33'(q_end_ff)) ? 33'(a_e) : 33'(q_end_ff);

   assign status.anno_hit = (a_c == q_chrom_ff) && (32'(a_k) < CLASS_COUNT) && a_meet;

   // pileup fields
   logic [30:0] p_s, p_e;
   logic [7:0]  p_c;
   logic [23:0] p_l;
   assign {p_s, p_e, p_c, p_l} = pile_rd_ff;

   logic signed [34:0] ps_x, pe_x, is_x, ie_x, hi_p, lo_p;
   logic               p_meet;
   logic [32:0]        plo, phi;
   always_comb begin
      ps_x = 35'(p_s);
      pe_x = 35'(p_e);
      is_x = 35'(is_ff);
      ie_x = 35'(ie_ff);
      hi_p = (pe_x > ie_x) ? pe_x : ie_x;
      lo_p = (ps_x < is_x) ? ps_x : is_x;
      p_meet = (hi_p - lo_p) <= ((pe_x - ps_x) + (ie_x - is_x));
      plo = (33'(p_s) > is_ff) ? 33'(p_s) : is_ff;
      phi = (33'(p_e) < ie_ff) ? 33'(p_e) : ie_ff;
   end

   logic [63:0] area_sum;
   logic [64:0] area_wide;

   always_comb begin
      area_wide  = {1'b0, area_ff[cls_ff]} + 65'(prod_ff);
      area_sum   = area_wide[64] ? '1 : area_wide[63:0];
   end

   function automatic logic [31:0] width_wide_n(input logic [31:0] w,
                                                input logic [32:0] lo,
                                                input logic [32:0] hi);
      logic [32:0] s;
      s = {1'b0, w} + ((hi > lo) ? (hi - lo) : 33'd0);
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.latch_query) begin
         q_chrom_ff <= req_data.chrom_id;
         q_start_ff <= req_data.item_start;
         q_end_ff   <= req_data.item_end;
      end
      if (cmd.anno_eval && status.anno_hit) begin
         is_ff  <= is_n;
         ie_ff  <= ie_n;
         cls_ff <= a_k;
         width_ff[a_k] <= width_wide_n(width_ff[a_k], is_n, ie_n);
         if (count_ff[a_k] != COUNT_MAX)
            count_ff[a_k] <= count_ff[a_k] + 13'd1;
      end
      len_ok_ff <= cmd.pile_eval && (p_c == q_chrom_ff) && p_meet;
      len_ff    <= (phi > plo) ? 32'(phi - plo) : 32'd0;
      lvl_ff    <= p_l;
      prod_ok_ff <= len_ok_ff;
      prod_ff    <= 56'(len_ff) * 56'(lvl_ff);
      if (cmd.prod_add && prod_ok_ff)
         area_ff[cls_ff] <= area_sum;
      if (cmd.clear_acc) begin
         for (int k = 0; k < CLASS_COUNT; k++) begin
            area_ff[k]  <= '0;
            width_ff[k] <= '0;
            count_ff[k] <= '0;
         end
      end
      if (reset) begin
         len_ok_ff  <= 1'b0;
         prod_ok_ff <= 1'b0;
      end
   end

   always_comb begin
      rsp_data.class_index = cmd.emit_class;
      rsp_data.class_area  = area_ff[cmd.emit_class];
      rsp_data.class_width = width_ff[cmd.emit_class];
      rsp_data.class_count = count_ff[cmd.emit_class];
      rsp_data.last_result = (32'(cmd.emit_class) == CLASS_COUNT - 1);
   end

endmodule

// ----- hw/rtl/iota_control.sv -----
// sequencer for loads, clears and query scans
module iota_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  iota_pkg::req_type      req_data,
   output logic                   busy,
   output logic                   anno_we,
   output logic [iota_pkg::ANNO_AW-1:0] anno_wa,
   output logic                   pile_we,
   output logic [iota_pkg::PILE_AW-1:0] pile_wa,
   output iota_pkg::dp_cmd_type   cmd,
   input  iota_pkg::dp_status_type status,
   output logic                   done
);
   import iota_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_ARD, S_AEV, S_PSCAN, S_DRAIN, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic [ANNO_AW:0] anno_fill_ff, anno_fill_in, a_ff, a_in;
   logic [PILE_AW:0] pile_fill_ff, pile_fill_in, p_ff, p_in;
   logic [1:0]       drain_ff, drain_in;
   logic [CLASS_W-1:0] k_ff, k_in;
   logic             acc;

   assign busy = (state_ff != S_IDLE);
   assign acc  = start && !busy;
   assign anno_we = acc && req_data.opcode == OP_LOAD_ANNO && 32'(anno_fill_ff) < ANNO_DEPTH;
   assign pile_we = acc && req_data.opcode == OP_LOAD_PILE && 32'(pile_fill_ff) < PILE_DEPTH;
   assign anno_wa = anno_fill_ff[ANNO_AW-1:0];
   assign pile_wa = pile_fill_ff[PILE_AW-1:0];

   always_comb begin
      state_in = state_ff;
      anno_fill_in = anno_fill_ff;
      pile_fill_in = pile_fill_ff;
      a_in = a_ff; p_in = p_ff; drain_in = drain_ff; k_in = k_ff;
      cmd = '0;
      cmd.anno_addr  = a_ff[ANNO_AW-1:0];
      cmd.pile_addr  = p_ff[PILE_AW-1:0];
      cmd.emit_class = k_ff;
      done = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (anno_we) anno_fill_in = anno_fill_ff + 1'b1;
            if (pile_we) pile_fill_in = pile_fill_ff + 1'b1;
            if (acc && req_data.opcode == OP_CLEAR) begin
               anno_fill_in = '0;
               pile_fill_in = '0;
            end
            if (acc && req_data.opcode == OP_QUERY) begin
               cmd.latch_query = 1'b1;
               cmd.clear_acc   = 1'b1;
               a_in = '0;
               state_in = S_ARD;
            end
         end
         S_ARD: begin
            if (a_ff >= anno_fill_ff) begin
               k_in = '0;
               state_in = S_EMIT;
            end else begin
               cmd.anno_rd = 1'b1;
               state_in = S_AEV;
            end
         end
         S_AEV: begin
            cmd.anno_eval = 1'b1;
            a_in = a_ff + 1'b1;
            p_in = '0;
            state_in = status.anno_hit ? S_PSCAN : S_ARD;
         end
         S_PSCAN: begin
            // one pileup read per cycle; each read is evaluated from the registered read data
            cmd.prod_add = 1'b1;
            cmd.pile_eval = (p_ff != '0);
            if (p_ff < pile_fill_ff) begin
               cmd.pile_rd = 1'b1;
               p_in = p_ff + 1'b1;
            end else begin
               drain_in = 2'd0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            cmd.prod_add = 1'b1;
            drain_in = drain_ff + 2'd1;
            if (drain_ff == 2'd2) state_in = S_ARD;
         end
         S_EMIT: begin
            done = 1'b1;
            k_in = k_ff + 1'b1;
            if (32'(k_ff) == CLASS_COUNT - 1) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         anno_fill_ff <= '0;
         pile_fill_ff <= '0;
         a_ff <= '0; p_ff <= '0; drain_ff <= '0; k_ff <= '0;
      end else begin
         state_ff <= state_in;
         anno_fill_ff <= anno_fill_in;
         pile_fill_ff <= pile_fill_in;
         a_ff <= a_in; p_ff <= p_in; drain_ff <= drain_in; k_ff <= k_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      32'(anno_fill_ff) <= ANNO_DEPTH) else $error("annotation fill overrun");
   assert property (@(posedge clock) disable iff (reset)
      32'(pile_fill_ff) <= PILE_DEPTH) else $error("pileup fill overrun");
   assert property (@(posedge clock) disable iff (reset)
      done |-> state_ff == S_EMIT) else $error("result outside emit");
endmodule

// ----- hw/rtl/interval_overlap_type_accumulator.sv -----
// top level of the interval overlap type accumulator
// loads and clears: one item per cycle, no result, busy stays low
// query: each annotation is read, then evaluated; each overlapping one scans the whole pileup
//   table and drains the product pipeline; a last check closes the scan, then one result per type
// busy is high from the cycle after a query is taken until its last result
// reset empties both tables (fill counts to zero); contents kept; results cannot stall
module interval_overlap_type_accumulator (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  iota_pkg::req_type req_data,
   output logic              rsp_valid,
   output iota_pkg::rsp_type rsp_data
);
   import iota_pkg::*;

   dp_cmd_type         cmd;
   dp_status_type      status;
   logic               anno_we, pile_we;
   logic [ANNO_AW-1:0] anno_wa;
   logic [PILE_AW-1:0] pile_wa;

   // sequencer owns fill counts and scan indices
   iota_control u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .busy(busy), .anno_we(anno_we), .anno_wa(anno_wa),
      .pile_we(pile_we), .pile_wa(pile_wa), .cmd(cmd), .status(status),
      .done(rsp_valid)
   );

   // memories and accumulators
   iota_datapath u_dp (
      .clock(clock), .reset(reset), .req_data(req_data),
      .anno_we(anno_we), .anno_wa(anno_wa), .pile_we(pile_we), .pile_wa(pile_wa),
      .cmd(cmd), .status(status), .rsp_data(rsp_data)
   );
endmodule

// ----- verif/interval_overlap_type_accumulator_tb.sv -----
// testbench for the interval overlap type accumulator: random and directed items with a scoreboard
`timescale 1ns / 100ps

module interval_overlap_type_accumulator_tb;
   import iota_pkg::*;

   // ------------------------------------------------------------------
   // tally of expected per-type results, fed from a table model
   // ------------------------------------------------------------------
   class overlap_tally;
      logic [30:0] a_st[ANNO_DEPTH];
      logic [31:0] a_en[ANNO_DEPTH];
      logic [7:0]  a_ch[ANNO_DEPTH];
      logic [2:0]  a_cl[ANNO_DEPTH];
      int          a_n = 0;
      logic [30:0] p_st[PILE_DEPTH];
      logic [30:0] p_en[PILE_DEPTH];
      logic [7:0]  p_ch[PILE_DEPTH];
      logic [23:0] p_lv[PILE_DEPTH];
      int          p_n = 0;
      rsp_type     pending[$];
      int          errors;
      int          checked;

      function bit meets(longint s1, longint e1, longint s2, longint e2);
         longint hi, lo;
         hi = (e1 > e2) ? e1 : e2;
         lo = (s1 < s2) ? s1 : s2;
         return (hi - lo) <= ((e1 - s1) + (e2 - s2));
      endfunction

      function void note_item(req_type r);
         logic [63:0] area[CLASS_COUNT];
         logic [63:0] wid[CLASS_COUNT];
         int          cnt[CLASS_COUNT];
         longint      qs, qe, is, ie, lo, hi;
         logic [63:0] add;
         logic [2:0]  c;
         rsp_type     x;
         case (opcode_type'(r.opcode))
            OP_LOAD_ANNO: if (a_n < ANNO_DEPTH) begin
               a_st[a_n] = r.item_start;
               a_en[a_n] = {1'b0, r.item_end} + 32'd1;
               a_ch[a_n] = r.chrom_id;
               a_cl[a_n] = r.region_class;
               a_n++;
            end
            OP_LOAD_PILE: if (p_n < PILE_DEPTH) begin
               p_st[p_n] = r.item_start;
               p_en[p_n] = r.item_end;
               p_ch[p_n] = r.chrom_id;
               p_lv[p_n] = r.pileup_level;
               p_n++;
            end
            OP_CLEAR: begin
               a_n = 0;
               p_n = 0;
            end
            default: begin
               for (int k = 0; k < CLASS_COUNT; k++) begin
                  area[k] = '0; wid[k] = '0; cnt[k] = 0;
               end
               qs = r.item_start;
               qe = r.item_end;
               for (int i = 0; i < a_n; i++) begin
                  c = a_cl[i];
                  if (a_ch[i] != r.chrom_id || c >= CLASS_COUNT) continue;
                  if (!meets(qs, qe, a_st[i], a_en[i])) continue;
                  is = (a_st[i] > qs) ? a_st[i] : qs;
                  ie = (a_en[i] < qe) ? a_en[i] : qe;
                  if (ie > is) wid[c] += ie - is;
                  if (wid[c] > 64'hFFFF_FFFF) wid[c] = 64'hFFFF_FFFF;
                  if (cnt[c] < COUNT_MAX) cnt[c]++;
                  for (int j = 0; j < p_n; j++) begin
                     if (p_ch[j] != r.chrom_id || !meets(p_st[j], p_en[j], is, ie)) continue;
                     lo = (p_st[j] > is) ? p_st[j] : is;
                     hi = (p_en[j] < ie) ? p_en[j] : ie;
                     add = (hi > lo) ? 64'(hi - lo) * p_lv[j] : 64'd0;
                     if (area[c] > ~add) area[c] = '1;
                     else area[c] += add;
                  end
               end
               for (int k = 0; k < CLASS_COUNT; k++) begin
                  x.class_index = k[2:0];
                  x.class_area  = area[k];
                  x.class_width = wid[k][31:0];
                  x.class_count = cnt[k][12:0];
                  x.last_result = (k == CLASS_COUNT - 1);
                  pending.insert(pending.size(), x);
               end
            end
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.class_index !== want.class_index)
            $display("%0t: class_index exp %0d got %0d", $time, want.class_index, got.class_index);
         if (got.class_area !== want.class_area)
            $display("%0t: class_area exp %0h got %0h", $time, want.class_area, got.class_area);
         if (got.class_width !== want.class_width)
            $display("%0t: class_width exp %0h got %0h", $time, want.class_width, got.class_width);
         if (got.class_count !== want.class_count)
            $display("%0t: class_count exp %0d got %0d", $time, want.class_count, got.class_count);
         if (got.last_result !== want.last_result)
            $display("%0t: last_result exp %0b got %0b", $time, want.last_result, got.last_result);
         if (got !== want) errors++;
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   overlap_tally tally;
   int unsigned  cycles;
   int           queries;
   int           items_sent;

   interval_overlap_type_accumulator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // results cannot be held off, so every strobe is checked at the edge
   always @(posedge clock) begin
      if (!reset && rsp_valid) tally.check_result(rsp_data);
   end

   // overall time limit, generous against long pileup scans
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 900000) begin
         $display("timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   // no gap half the time, otherwise mostly short gaps, now and then a long one
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) < 5) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // offer one item and hold it until the block takes it
   task automatic send_item(req_type r);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      tally.note_item(r);
      items_sent++;
      if (opcode_type'(r.opcode) == OP_QUERY) queries++;
      idle_gap();
   endtask

   function automatic req_type make_item(opcode_type op, logic [7:0] ch, logic [30:0] s,
                                         logic [30:0] e, logic [2:0] cl, logic [23:0] lv);
      req_type r;
      r.opcode = op; r.chrom_id = ch; r.item_start = s; r.item_end = e;
      r.region_class = cl; r.pileup_level = lv;
      return r;
   endfunction

   // random item aimed at a small coordinate window so overlaps are common
   function automatic req_type random_item(opcode_type op);
      req_type     r;
      logic [30:0] s;
      s = 31'($urandom_range(0, 400));
      r = make_item(op, 8'($urandom_range(0, 2)), s, s + 31'($urandom_range(0, 120)),
                    3'($urandom_range(0, 7)), 24'($urandom));
      // an occasional wild item covers the high bits and reversed spans
      if ($urandom_range(0, 9) == 0) begin
         r.chrom_id   = 8'($urandom);
         r.item_start = 31'($urandom);
         r.item_end   = 31'($urandom);
      end
      return r;
   endfunction

   task automatic wait_drained();
      start <= 1'b0;
      while (tally.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      tally      = new();
      start      = 1'b0;
      req_data   = '0;
      reset      = 1'b1;
      cycles     = 0;
      queries    = 0;
      items_sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: query on empty tables, then field extremes
      send_item(make_item(OP_QUERY, 8'd0, 31'd0, 31'd100, 3'd0, 24'd0));
      send_item(make_item(OP_LOAD_ANNO, 8'd0, 31'd10, 31'd50, 3'd0, 24'hFFFFFF));
      send_item(make_item(OP_LOAD_ANNO, 8'd0, 31'd40, 31'd90, 3'd7, 24'd0));
      // reversed annotation span
      send_item(make_item(OP_LOAD_ANNO, 8'd0, 31'd80, 31'd60, 3'd3, 24'd0));
      send_item(make_item(OP_LOAD_ANNO, 8'd1, 31'd20, 31'd30, 3'd5, 24'd0));
      send_item(make_item(OP_LOAD_PILE, 8'd0, 31'd0, 31'd60, 3'd0, 24'hFFFFFF));
      send_item(make_item(OP_LOAD_PILE, 8'd0, 31'd45, 31'd45, 3'd7, 24'd256));
      // reversed pileup span
      send_item(make_item(OP_LOAD_PILE, 8'd0, 31'd70, 31'd50, 3'd0, 24'd1));
      send_item(make_item(OP_QUERY, 8'd0, 31'd0, 31'd100, 3'd7, 24'hFFFFFF));
      // touching edge only
      send_item(make_item(OP_QUERY, 8'd0, 31'd91, 31'd95, 3'd0, 24'd0));
      send_item(make_item(OP_QUERY, 8'd1, 31'd0, 31'h7FFFFFFF, 3'd0, 24'd0));
      // reversed query
      send_item(make_item(OP_QUERY, 8'd0, 31'd60, 31'd20, 3'd0, 24'd0));
      // extreme coordinates and chromosome
      send_item(make_item(OP_LOAD_ANNO, 8'hFF, 31'h7FFFFFF0, 31'h7FFFFFFF, 3'd2, 24'd0));
      send_item(make_item(OP_LOAD_PILE, 8'hFF, 31'h7FFFFFF0, 31'h7FFFFFFF, 3'd0, 24'hFFFFFF));
      send_item(make_item(OP_QUERY, 8'hFF, 31'h7FFFFFF8, 31'h7FFFFFFF, 3'd0, 24'd0));
      send_item(make_item(OP_CLEAR, 8'd0, 31'd0, 31'd0, 3'd0, 24'd0));
      send_item(make_item(OP_QUERY, 8'd0, 31'd0, 31'd100, 3'd0, 24'd0));

      // hold off until every result of the directed part is in
      wait_drained();

      // random: bursts of loads followed by queries, a clear or a random item now and then
      while (items_sent < 118) begin
         repeat ($urandom_range(2, 10))
            send_item(random_item($urandom_range(0, 1) ? OP_LOAD_ANNO : OP_LOAD_PILE));
         repeat ($urandom_range(1, 3)) send_item(random_item(OP_QUERY));
         if ($urandom_range(0, 7) == 0) send_item(random_item(OP_CLEAR));
         if ($urandom_range(0, 5) == 0) send_item(random_item(opcode_type'($urandom_range(0, 3))));
      end

      wait_drained();
      repeat (20) @(posedge clock);

      $display("%0d items sent, %0d queries, %0d results checked",
               items_sent, queries, tally.checked);
      $display("covered loads, clears, reversed and touching spans, extreme fields");
      if (tally.errors == 0 && tally.pending.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
